// ===== rtl/checked_integer_alu_defines.svh =====
// Assertion macros for the checked integer ALU.
// The asserting scope must have clk_i and rst_ni.
`ifndef CHECKED_INTEGER_ALU_DEFINES_SVH
`define CHECKED_INTEGER_ALU_DEFINES_SVH

// Same-cycle implication, disabled in reset
`define CHK_ASSERT_IMM(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled in reset
`define CHK_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/chk_pkg.sv =====
// ----------------------------------------------------------------------------
// chk_pkg
// Shared types and constants of the checked integer ALU.
// ----------------------------------------------------------------------------
`default_nettype none

package chk_pkg;

  localparam int DATA_W    = 64;
  localparam int WORD_BITS = 32;
  localparam int LONG_BITS = 64;
  localparam int BYTE_MIN  = -128;
  localparam int BYTE_BITS = 8;
  localparam int MUL_H     = DATA_W / 2;
  localparam int NDIV      = DATA_W;
  localparam int QDEPTH    = 2;
  localparam int QPTR_W    = $clog2(QDEPTH);
  localparam int QCNT_W    = $clog2(QDEPTH + 1);

  // Magnitude limits of a product (non-negative case adds one less)
  localparam logic [DATA_W-1:0] LIM_BYTE = DATA_W'(1) << (BYTE_BITS - 1);
  localparam logic [DATA_W-1:0] LIM_WORD = DATA_W'(1) << (WORD_BITS - 1);
  localparam logic [DATA_W-1:0] LIM_LONG = DATA_W'(1) << (LONG_BITS - 1);

  typedef enum logic [2:0] {
    OP_ADD = 3'd0,
    OP_MUL = 3'd1,
    OP_DIV = 3'd2,
    OP_REM = 3'd3,
    OP_MOD = 3'd4,
    OP_CMP = 3'd5
  } mode_e;

  typedef enum logic [1:0] {
    SZ_BYTE = 2'd0,
    SZ_WORD = 2'd1,
    SZ_LONG = 2'd2
  } size_e;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_OVF  = 2'd1,
    ST_DIVZ = 2'd2
  } status_e;

  // One classified request as it travels through queue and back end
  typedef struct packed {
    mode_e             mode;
    logic [1:0]        size;
    logic              a_neg;
    logic              b_neg;
    logic [DATA_W-1:0] b;
    logic [DATA_W-1:0] ub;
    logic [DATA_W-1:0] rem;
    logic [DATA_W-1:0] aq;
    logic [DATA_W-1:0] res;
    status_e           st;
    logic              done;
  } item_t;

endpackage

`default_nettype wire

// ===== rtl/chk_if.sv =====
// ----------------------------------------------------------------------------
// chk_if
// Valid/ready channels for requests and results of the checked integer ALU.
// ----------------------------------------------------------------------------
`default_nettype none

interface chk_in_if;
  logic               valid;
  logic               ready;
  logic [2:0]         mode;
  logic [1:0]         size;
  logic signed [63:0] left_operand;
  logic signed [63:0] right_operand;

  modport source (output valid, mode, size, left_operand, right_operand, input ready);
  modport sink   (input valid, mode, size, left_operand, right_operand, output ready);
endinterface

interface chk_out_if;
  logic               valid;
  logic               ready;
  logic signed [63:0] result;
  logic [1:0]         status;

  modport source (output valid, result, status, input ready);
  modport sink   (input valid, result, status, output ready);
endinterface

`default_nettype wire

// ===== rtl/chk_front.sv =====
// ----------------------------------------------------------------------------
// chk_front
// Classifies a request: sign extension, magnitudes, and the operations that
// finish at once (add, compare, division by zero, MIN / -1, unused codes).
// ----------------------------------------------------------------------------
`default_nettype none

module chk_front import chk_pkg::*; (
  chk_in_if.sink in_i,
  output item_t  item_o
);

  logic                      is_long;
  logic signed [WORD_BITS-1:0] lw, rw;
  logic signed [LONG_BITS-1:0] ll, rl;
  logic signed [DATA_W-1:0]  a, b;
  logic signed [DATA_W:0]    sum;
  logic                      fit8, fitw, fitl, fit_k;
  logic                      a_min, b_m1, a_b128;

  always_comb begin
    is_long = !(in_i.size == SZ_BYTE || in_i.size == SZ_WORD);
    lw = in_i.left_operand[WORD_BITS-1:0];
    rw = in_i.right_operand[WORD_BITS-1:0];
    ll = in_i.left_operand[LONG_BITS-1:0];
    rl = in_i.right_operand[LONG_BITS-1:0];
    a  = is_long ? DATA_W'(ll) : DATA_W'(lw);
    b  = is_long ? DATA_W'(rl) : DATA_W'(rw);

    // exact sum and range checks
    sum  = (DATA_W+1)'(a) + (DATA_W+1)'(b);
    fit8 = (&sum[DATA_W:BYTE_BITS-1]) || !(|sum[DATA_W:BYTE_BITS-1]);
    fitw = (&sum[DATA_W:WORD_BITS-1]) || !(|sum[DATA_W:WORD_BITS-1]);
    fitl = (&sum[DATA_W:LONG_BITS-1]) || !(|sum[DATA_W:LONG_BITS-1]);
    fit_k = (in_i.size == SZ_BYTE) ? fit8 : (is_long ? fitl : fitw);

    // most negative value of the operand width
    if (is_long) begin
      a_min = (&a[DATA_W-1:LONG_BITS-1]) && !(|a[LONG_BITS-2:0]);
    end else begin
      a_min = (&a[DATA_W-1:WORD_BITS-1]) && !(|a[WORD_BITS-2:0]);
    end
    b_m1   = &b;
    a_b128 = (a == DATA_W'(BYTE_MIN));

    item_o.mode  = mode_e'(in_i.mode);
    item_o.size  = in_i.size;
    item_o.a_neg = a[DATA_W-1];
    item_o.b_neg = b[DATA_W-1];
    item_o.b     = b;
    item_o.ub    = b[DATA_W-1] ? (DATA_W'(0) - b) : b;
    item_o.aq    = a[DATA_W-1] ? (DATA_W'(0) - a) : a;
    item_o.rem   = '0;
    item_o.res   = '0;
    item_o.st    = ST_OK;
    item_o.done  = 1'b0;

    case (mode_e'(in_i.mode))
      OP_ADD: begin
        item_o.done = 1'b1;
        if (fit_k) item_o.res = sum[DATA_W-1:0];
        else       item_o.st  = ST_OVF;
      end
      OP_CMP: begin
        item_o.done = 1'b1;
        if (b == a)     item_o.res = DATA_W'(1);
        else if (b < a) item_o.res = DATA_W'(2);
      end
      OP_MUL: ;
      OP_DIV, OP_REM, OP_MOD: begin
        if (b == '0) begin
          item_o.done = 1'b1;
          item_o.st   = ST_DIVZ;
        end else if (in_i.mode == OP_DIV && b_m1 &&
                     (a_min || (in_i.size == SZ_BYTE && a_b128))) begin
          item_o.done = 1'b1;
          item_o.st   = ST_OVF;
        end
      end
      default: item_o.done = 1'b1;
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/chk_fifo.sv =====
// ----------------------------------------------------------------------------
// chk_fifo
// Short queue of classified requests between front and back end.
// ----------------------------------------------------------------------------
`default_nettype none

module chk_fifo import chk_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  item_t item_i,
  output logic  full_o,
  input  logic  pop_i,
  output logic  valid_o,
  output item_t item_o
);

  item_t             mem_q [QDEPTH];
  logic [QPTR_W-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [QCNT_W-1:0] cnt_q, cnt_d;
  logic              do_push, do_pop;

  assign full_o  = (cnt_q == QCNT_W'(QDEPTH));
  assign valid_o = (cnt_q != '0);
  assign item_o  = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  // pointer and fill count
  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) wr_d = (wr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_q + 1'b1;
    if (do_pop)  rd_d = (rd_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_q + 1'b1;
    if (do_push && !do_pop)      cnt_d = cnt_q + 1'b1;
    else if (!do_push && do_pop) cnt_d = cnt_q - 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_q] <= item_i;
  end

endmodule

`default_nettype wire

// ===== rtl/chk_back.sv =====
// ----------------------------------------------------------------------------
// chk_back
// Execution pipeline: one restoring-division step per stage, a two-stage
// split multiplier beside the first stages, sign fix-up into the result
// register.
// ----------------------------------------------------------------------------
`default_nettype none

module chk_back import chk_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  item_t     item_i,
  input  logic      valid_i,
  output logic      pop_o,
  chk_out_if.source out_o
);

  item_t                 stg_q [NDIV];
  item_t                 stg_d [NDIV];
  logic [NDIV-1:0]       vld_q;
  logic                  en;
  logic [DATA_W-1:0]     pp_q [4];
  logic [2*DATA_W-1:0]   prod_q, prod_d;
  logic [MUL_H+1:0]      mid;
  logic [DATA_W-1:0]     hi;
  item_t                 last;
  logic [DATA_W-1:0]     fin_res, fx;
  logic                  out_vld_q;
  logic [DATA_W-1:0]     out_res_q;
  status_e               out_st_q;

  // whole pipe advances while the result register is free or being taken
  assign en    = !out_vld_q || out_o.ready;
  assign pop_o = en && valid_i;

  // one division step
  function automatic item_t div_step(item_t d);
    logic [DATA_W:0] t, df;
    item_t           r;
    r  = d;
    t  = {d.rem, d.aq[DATA_W-1]};
    df = t - {1'b0, d.ub};
    if (t >= {1'b0, d.ub}) begin
      r.rem = df[DATA_W-1:0];
      r.aq  = {d.aq[DATA_W-2:0], 1'b1};
    end else begin
      r.rem = t[DATA_W-1:0];
      r.aq  = {d.aq[DATA_W-2:0], 1'b0};
    end
    return r;
  endfunction

  // product range check and sign
  function automatic item_t mul_fix(item_t d, logic [2*DATA_W-1:0] p);
    logic              neg;
    logic [DATA_W-1:0] lim, lo;
    item_t             r;
    r   = d;
    neg = d.a_neg ^ d.b_neg;
    lo  = p[DATA_W-1:0];
    case (d.size)
      SZ_BYTE: lim = LIM_BYTE;
      SZ_WORD: lim = LIM_WORD;
      default: lim = LIM_LONG;
    endcase
    if (!neg) lim = lim - 1'b1;
    r.done = 1'b1;
    if ((p[2*DATA_W-1:DATA_W] != '0) || (lo > lim)) begin
      r.st  = ST_OVF;
      r.res = '0;
    end else begin
      r.res = neg ? (DATA_W'(0) - lo) : lo;
    end
    return r;
  endfunction

  // partial products summed into the full product
  always_comb begin
    mid = (MUL_H+2)'(pp_q[0][DATA_W-1:MUL_H]) + (MUL_H+2)'(pp_q[1][MUL_H-1:0])
        + (MUL_H+2)'(pp_q[2][MUL_H-1:0]);
    hi  = pp_q[3] + DATA_W'(pp_q[1][DATA_W-1:MUL_H]) + DATA_W'(pp_q[2][DATA_W-1:MUL_H])
        + DATA_W'(mid[MUL_H+1:MUL_H]);
    prod_d = {hi, mid[MUL_H-1:0], pp_q[0][MUL_H-1:0]};
  end

  // stage logic
  for (genvar i = 0; i < NDIV; i++) begin : g_stg
    if (i == 0) begin : g_first
      assign stg_d[i] = div_step(item_i);
    end else if (i == 2) begin : g_mul
      always_comb begin
        if (stg_q[i-1].mode == OP_MUL && !stg_q[i-1].done) begin
          stg_d[i] = mul_fix(stg_q[i-1], prod_q);
        end else begin
          stg_d[i] = div_step(stg_q[i-1]);
        end
      end
    end else begin : g_mid
      assign stg_d[i] = div_step(stg_q[i-1]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[NDIV-2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int j = 0; j < NDIV; j++) stg_q[j] <= stg_d[j];
      pp_q[0] <= DATA_W'(item_i.aq[MUL_H-1:0]) * DATA_W'(item_i.ub[MUL_H-1:0]);
      pp_q[1] <= DATA_W'(item_i.aq[MUL_H-1:0]) * DATA_W'(item_i.ub[DATA_W-1:MUL_H]);
      pp_q[2] <= DATA_W'(item_i.aq[DATA_W-1:MUL_H]) * DATA_W'(item_i.ub[MUL_H-1:0]);
      pp_q[3] <= DATA_W'(item_i.aq[DATA_W-1:MUL_H]) * DATA_W'(item_i.ub[DATA_W-1:MUL_H]);
      prod_q  <= prod_d;
    end
  end

  // sign fix-up of quotient and remainder
  assign last = stg_q[NDIV-1];
  always_comb begin
    fx      = last.a_neg ? (DATA_W'(0) - last.rem) : last.rem;
    fin_res = last.res;
    if (!last.done) begin
      case (last.mode)
        OP_DIV:  fin_res = (last.a_neg ^ last.b_neg) ? (DATA_W'(0) - last.aq) : last.aq;
        OP_REM:  fin_res = fx;
        OP_MOD:  fin_res = ((last.rem != '0) && (last.a_neg != last.b_neg)) ? fx + last.b : fx;
        default: fin_res = last.res;
      endcase
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (en) begin
      out_vld_q <= vld_q[NDIV-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_res_q <= fin_res;
      out_st_q  <= last.st;
    end
  end

  assign out_o.valid  = out_vld_q;
  assign out_o.result = out_res_q;
  assign out_o.status = out_st_q;

endmodule

`default_nettype wire

// ===== rtl/checked_integer_alu.sv =====
// ----------------------------------------------------------------------------
// checked_integer_alu
// Signed integer ALU with overflow and division-by-zero checks.
// ----------------------------------------------------------------------------
// Takes one request per clock while the queue is not full and returns one
// result per request, in order. Every request is held in the two-entry
// request queue and then passes through the division pipeline (one quotient
// bit per stage), whose last stage loads the result register. Add, compare
// and the checked cases are resolved on entry; multiply uses a split 32x32
// multiplier in the first pipeline stages. A stall on the result side
// freezes the pipeline, and requests keep being taken until the queue is
// full.
`default_nettype none

module checked_integer_alu import chk_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  chk_in_if.sink    in_i,
  chk_out_if.source out_o
);

  item_t front_item, q_item;
  logic  q_full, q_vld, q_pop;

  assign in_i.ready = !q_full;

  chk_front u_front (
    .in_i   (in_i),
    .item_o (front_item)
  );

  chk_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (in_i.valid),
    .item_i  (front_item),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_vld),
    .item_o  (q_item)
  );

  chk_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .item_i  (q_item),
    .valid_i (q_vld),
    .pop_o   (q_pop),
    .out_o   (out_o)
  );

endmodule

`default_nettype wire

// ===== rtl/chk_checker.sv =====
// ----------------------------------------------------------------------------
// chk_checker
// Port-level checks on the result channel of the checked integer ALU.
// ----------------------------------------------------------------------------
`default_nettype none
`include "checked_integer_alu_defines.svh"

module chk_checker import chk_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [63:0] result_i,
  input logic [1:0]  status_i
);

  // a stalled result holds
  `CHK_ASSERT_NXT(a_out_hold, out_valid_i && !out_ready_i, out_valid_i && $stable(result_i) && $stable(status_i), "result changed while stalled")

  // only defined status codes
  `CHK_ASSERT_IMM(a_status_code, out_valid_i, status_i == ST_OK || status_i == ST_OVF || status_i == ST_DIVZ, "undefined status code")

  // a failed operation returns zero
  `CHK_ASSERT_IMM(a_fail_zero, out_valid_i && status_i != ST_OK, result_i == '0, "non-zero result with error status")

endmodule

bind checked_integer_alu chk_checker u_chk_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .result_i    (out_o.result),
  .status_i    (out_o.status)
);

`default_nettype wire
